### rtl/assert_macros.svh
// assertion macros shared by the controller, datapath and top-level rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every edge, reset included
`define CHECK_IMPLY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/ieu_pkg.sv
// shared types, opcodes and constants of the integer execute unit
package ieu_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int OP_WIDTH = 5;

   // opcodes
   localparam logic [OP_WIDTH-1:0] OP_NOP   = 5'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOAD  = 5'd1;
   localparam logic [OP_WIDTH-1:0] OP_ADD   = 5'd2;
   localparam logic [OP_WIDTH-1:0] OP_SUB   = 5'd3;
   localparam logic [OP_WIDTH-1:0] OP_MUL   = 5'd4;
   localparam logic [OP_WIDTH-1:0] OP_DIV   = 5'd5;
   localparam logic [OP_WIDTH-1:0] OP_MOD   = 5'd6;
   localparam logic [OP_WIDTH-1:0] OP_AND   = 5'd7;
   localparam logic [OP_WIDTH-1:0] OP_OR    = 5'd8;
   localparam logic [OP_WIDTH-1:0] OP_XOR   = 5'd9;
   localparam logic [OP_WIDTH-1:0] OP_SHL   = 5'd10;
   localparam logic [OP_WIDTH-1:0] OP_SHR   = 5'd11;
   localparam logic [OP_WIDTH-1:0] OP_NOT   = 5'd12;
   localparam logic [OP_WIDTH-1:0] OP_SHRA  = 5'd13;
   localparam logic [OP_WIDTH-1:0] OP_COMP  = 5'd14;
   localparam logic [OP_WIDTH-1:0] OP_JUMP  = 5'd15;
   localparam logic [OP_WIDTH-1:0] OP_JNEG  = 5'd16;
   localparam logic [OP_WIDTH-1:0] OP_JZER  = 5'd17;
   localparam logic [OP_WIDTH-1:0] OP_JPOS  = 5'd18;
   localparam logic [OP_WIDTH-1:0] OP_JNNEG = 5'd19;
   localparam logic [OP_WIDTH-1:0] OP_JNZER = 5'd20;
   localparam logic [OP_WIDTH-1:0] OP_JNPOS = 5'd21;
   localparam logic [OP_WIDTH-1:0] OP_JLES  = 5'd22;
   localparam logic [OP_WIDTH-1:0] OP_JEQU  = 5'd23;
   localparam logic [OP_WIDTH-1:0] OP_JGRE  = 5'd24;
   localparam logic [OP_WIDTH-1:0] OP_JNLES = 5'd25;
   localparam logic [OP_WIDTH-1:0] OP_JNEQU = 5'd26;
   localparam logic [OP_WIDTH-1:0] OP_JNGRE = 5'd27;

   // status flags
   typedef struct packed {
      logic zdiv;
      logic ovf;
      logic eq;
      logic lt;
      logic gt;
   } flags_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture operands, run simple ops
      logic div_start; // prime the divider
      logic div_step;  // one radix-2 iteration
      logic div_done;  // fix signs and write result
      logic mul_step;  // take the registered product
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_div;
      logic is_mul;
      logic div_last;
   } stat_type;

   // input transaction
   typedef struct packed {
      logic [OP_WIDTH-1:0]    op;
      logic [FIELD_WIDTH-1:0] alu_a;
      logic [FIELD_WIDTH-1:0] alu_b;
      logic [FIELD_WIDTH-1:0] reg_value;
      logic [FIELD_WIDTH-1:0] second_operand;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [FIELD_WIDTH-1:0] result;
      logic                   write_result;
      logic                   branch_taken;
      logic [FIELD_WIDTH-1:0] branch_target;
      logic                   greater_flag;
      logic                   less_flag;
      logic                   equal_flag;
      logic                   overflow_flag;
      logic                   divide_by_zero_flag;
   } rsp_type;

endpackage

### rtl/ieu_if.sv
// valid/ready channel carrying one payload struct
interface ieu_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/ieu_ctrl.sv
// controller state machine sequencing the datapath
`include "assert_macros.svh"
module ieu_ctrl #(
   parameter int DATA_WIDTH = ieu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ieu_pkg::stat_type stat,
   output ieu_pkg::cmd_type  cmd
);
   import ieu_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_FIX  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in = ST_OUT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = ST_FIX;
         end
         ST_FIX: begin
            cmd.div_done = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // first cycle after load may redirect to a multi-cycle op
            if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else if (stat.is_mul) begin
               state_in = ST_MUL;
            end else begin
               rsp_valid = 1'b1;
               if (rsp_ready) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `CHECK_ALWAYS(a_state_onehot, clock, reset, $onehot(state_ff), "state not one-hot")
   `CHECK_ALWAYS(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready while holding result")
   `CHECK_ALWAYS(a_div_exit, clock, reset,
      (state_ff == ST_FIX) |-> $past(state_ff == ST_DIV), "fix without divide")

endmodule

### rtl/ieu_dp.sv
// datapath: operand registers, simple ops, multiplier and radix-2 divider
`include "assert_macros.svh"
module ieu_dp #(
   parameter int DATA_WIDTH = ieu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ieu_pkg::cmd_type  cmd,
   input  ieu_pkg::req_type  req,
   output ieu_pkg::stat_type stat,
   output ieu_pkg::rsp_type  rsp
);
   import ieu_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);
   localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

   // operand and control registers
   logic [OP_WIDTH-1:0] op_ff;
   logic [W-1:0] a_ff, b_ff;
   logic [W-1:0] res_ff, res_in;
   logic wr_ff, wr_in, jmp_ff, jmp_in;
   logic [W-1:0] tgt_ff, tgt_in;
   flags_type flags_ff, flags_in;
   logic is_div_ff, is_div_in, is_mul_ff, is_mul_in;
   logic [2*W-1:0] prod_ff;
   logic mul_ovf_ff;
   logic [W-1:0] quo_ff, rem_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;

   // operands sign-extended or cut to the working width
   logic [W-1:0] a, b, r, s;
   assign a = W'($signed(req.alu_a));
   assign b = W'($signed(req.alu_b));
   assign r = W'($signed(req.reg_value));
   assign s = W'($signed(req.second_operand));

   logic [W-1:0] sum, dif, sra;
   logic big_s, big_b;
   assign sum = a + b;
   assign dif = a - b;
   assign big_s = (s >= W'(W));
   assign big_b = (b >= W'(W));
   assign sra = $unsigned($signed(r) >>> s[CW-1:0]);

   // simple operations and flags at load, then the multiply and divide results and their overflow
   always_comb begin
      res_in = res_ff;
      wr_in = wr_ff;
      jmp_in = jmp_ff;
      tgt_in = tgt_ff;
      flags_in = flags_ff;
      is_div_in = 1'b0;
      is_mul_in = 1'b0;
      if (cmd.load) begin
         res_in = '0;
         wr_in = 1'b0;
         jmp_in = 1'b0;
         case (req.op)
            OP_LOAD: begin res_in = s; wr_in = 1'b1; end
            OP_ADD: begin
               res_in = sum; wr_in = 1'b1;
               if (a[W-1] == b[W-1] && sum[W-1] != a[W-1]) flags_in.ovf = 1'b1;
            end
            OP_SUB: begin
               res_in = dif; wr_in = 1'b1;
               if (a[W-1] != b[W-1] && dif[W-1] != a[W-1]) flags_in.ovf = 1'b1;
            end
            OP_MUL: is_mul_in = 1'b1;
            OP_DIV, OP_MOD: begin
               if (b == '0) flags_in.zdiv = 1'b1;
               else is_div_in = 1'b1;
            end
            OP_AND: begin res_in = a & b; wr_in = 1'b1; end
            OP_OR:  begin res_in = a | b; wr_in = 1'b1; end
            OP_XOR: begin res_in = a ^ b; wr_in = 1'b1; end
            OP_SHL: begin
               res_in = big_b ? '0 : (a << b[CW-1:0]); wr_in = 1'b1;
            end
            OP_SHR: begin
               res_in = big_s ? '0 : (r >> s[CW-1:0]); wr_in = 1'b1;
            end
            OP_NOT: begin res_in = ~a; wr_in = 1'b1; end
            OP_SHRA: begin
               res_in = big_s ? {W{r[W-1]}} : sra; wr_in = 1'b1;
            end
            OP_COMP: begin
               flags_in.gt = $signed(a) > $signed(b);
               flags_in.lt = $signed(a) < $signed(b);
               flags_in.eq = (a == b);
            end
            OP_JUMP:  jmp_in = 1'b1;
            OP_JNEG:  jmp_in = r[W-1];
            OP_JZER:  jmp_in = (r == '0);
            OP_JPOS:  jmp_in = !r[W-1] && r != '0;
            OP_JNNEG: jmp_in = !r[W-1];
            OP_JNZER: jmp_in = (r != '0);
            OP_JNPOS: jmp_in = r[W-1] || r == '0;
            OP_JLES:  jmp_in = flags_ff.lt;
            OP_JEQU:  jmp_in = flags_ff.eq;
            OP_JGRE:  jmp_in = flags_ff.gt;
            OP_JNLES: jmp_in = !flags_ff.lt;
            OP_JNEQU: jmp_in = !flags_ff.eq;
            OP_JNGRE: jmp_in = !flags_ff.gt;
            default: ;
         endcase
         tgt_in = jmp_in ? s : '0;
      end else if (cmd.mul_step) begin
         res_in = prod_ff[W-1:0];
         wr_in = 1'b1;
         if (mul_ovf_ff) flags_in.ovf = 1'b1;
      end else if (cmd.div_done) begin
         wr_in = 1'b1;
         if (op_ff == OP_DIV) begin
            if (a_ff[W-1] != b_ff[W-1]) res_in = -quo_ff;
            else begin
               res_in = quo_ff;
               if (quo_ff > SMAX) flags_in.ovf = 1'b1;
            end
         end else begin
            res_in = a_ff[W-1] ? -rem_ff : rem_ff;
         end
      end
   end

   // signed product and magnitude product for the overflow test; product and overflow test are registered at load
   logic [2*W-1:0] prod_in;
   logic [W-1:0] ma_c, mb_c;
   assign prod_in = $unsigned($signed(a) * $signed(b));
   assign ma_c = a[W-1] ? -a : a;
   assign mb_c = b[W-1] ? -b : b;
   logic [2*W-1:0] mag_prod;
   logic mag_neg;
   assign mag_prod = {{W{1'b0}}, ma_c} * {{W{1'b0}}, mb_c};
   assign mag_neg = a[W-1] != b[W-1];

   // divider registers
   logic [W-1:0] ma_ff;
   logic [W:0]   trial;
   logic [W-1:0] rem_sh;
   assign rem_sh = {rem_ff[W-2:0], ma_ff[W-1]};
   assign trial = {1'b0, rem_sh} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         wr_ff <= 1'b0;
         jmp_ff <= 1'b0;
         is_div_ff <= 1'b0;
         is_mul_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         flags_ff <= flags_in;
         wr_ff <= wr_in;
         jmp_ff <= jmp_in;
         is_div_ff <= is_div_in;
         is_mul_ff <= is_mul_in;
         if (cmd.div_start) cnt_ff <= CW'(W);
         else if (cmd.div_step) cnt_ff <= cnt_ff - 1'b1;
      end
      res_ff <= res_in;
      tgt_ff <= tgt_in;
      if (cmd.load) begin
         op_ff <= req.op;
         a_ff <= a;
         b_ff <= b;
         prod_ff <= prod_in;
         // magnitude product exceeds the signed limit
         mul_ovf_ff <= mag_neg ? (mag_prod > {{W{1'b0}}, SMIN})
                               : (mag_prod > {{W{1'b0}}, SMAX});
         ma_ff <= ma_c;
         dvs_ff <= mb_c;
      end
      if (cmd.div_start) begin
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         ma_ff <= {ma_ff[W-2:0], 1'b0};
         if (!trial[W]) begin
            rem_ff <= trial[W-1:0];
            quo_ff <= {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[W-2:0], 1'b0};
         end
      end
   end

   assign stat.is_div = is_div_ff;
   assign stat.is_mul = is_mul_ff;
   assign stat.div_last = (cnt_ff == CW'(1));

   // widen to the field width
   always_comb begin
      rsp.result = FIELD_WIDTH'($signed(res_ff));
      rsp.write_result = wr_ff;
      rsp.branch_taken = jmp_ff;
      rsp.branch_target = FIELD_WIDTH'($signed(tgt_ff));
      rsp.greater_flag = flags_ff.gt;
      rsp.less_flag = flags_ff.lt;
      rsp.equal_flag = flags_ff.eq;
      rsp.overflow_flag = flags_ff.ovf;
      rsp.divide_by_zero_flag = flags_ff.zdiv;
   end

   `CHECK_ALWAYS(a_cmp_onehot, clock, reset,
      $past(cmd.load && req.op == OP_COMP) |-> $onehot({flags_ff.gt, flags_ff.lt, flags_ff.eq}),
      "compare flags not one-hot")
   `CHECK_ALWAYS(a_ovf_sticky, clock, reset, $past(flags_ff.ovf) |-> flags_ff.ovf,
      "overflow flag cleared")
   `CHECK_ALWAYS(a_zdiv_sticky, clock, reset, $past(flags_ff.zdiv) |-> flags_ff.zdiv,
      "divide-by-zero flag cleared")

endmodule

### rtl/integer_execute_unit_with_flags.sv
// top level of the integer execute unit with status flags
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    op, alu_a, alu_b, reg_value, second_operand
//  rsp      out  valid / ready    result, flags, branch fields
//
// most instructions: accept, then result held in output registers
// mul: product and overflow test are registered at accept, then taken as result
// div and mod: run the radix-2 divider iterations, then fix the signs
// a zero divisor skips the divider and sets the divide-by-zero flag
// one transaction at a time; a stalled result holds until taken
// synchronous reset clears state and all five status flags
`include "assert_macros.svh"
module integer_execute_unit_with_flags #(
   parameter int DATA_WIDTH = ieu_pkg::DATA_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   ieu_if.sink   req,
   ieu_if.source rsp
);
   import ieu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ieu_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ieu_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req.payload),
      .stat  (stat),
      .rsp   (rsp.payload)
   );

endmodule

### tb/integer_execute_unit_with_flags_checker.sv
// transaction monitor, flag predictor and scoreboard for the integer execute unit
`timescale 1ns / 1ps
module integer_execute_unit_with_flags_checker
   import ieu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ieu_if       req_mon,
   ieu_if       rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   localparam logic [31:0] MOST_NEG = 32'h8000_0000;

   rsp_type   expected_rsp_q[$];
   flags_type model_flags;

   // one line per mismatch, counted
   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      fail_count++;
      $display("%0t mismatch on %s: got %h expected %h", $realtime, field, got, want);
   endtask

   // predict one result transaction and advance the model flags
   function automatic rsp_type execute_op(input req_type t);
      rsp_type     o;
      logic [31:0] a, b, r, s, res, qa, qb, q;
      logic [63:0] prod;
      logic        wr, jmp;
      flags_type   f;
      a = t.alu_a;
      b = t.alu_b;
      r = t.reg_value;
      s = t.second_operand;
      res = '0;
      wr = 1'b0;
      jmp = 1'b0;
      f = model_flags;
      qa = a[31] ? -a : a;
      qb = b[31] ? -b : b;
      case (t.op)
         OP_LOAD: begin res = s; wr = 1'b1; end
         OP_ADD: begin
            res = a + b; wr = 1'b1;
            if (a[31] == b[31] && res[31] != a[31]) f.ovf = 1'b1;
         end
         OP_SUB: begin
            res = a - b; wr = 1'b1;
            if (a[31] != b[31] && res[31] != a[31]) f.ovf = 1'b1;
         end
         OP_MUL: begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            res = prod[31:0]; wr = 1'b1;
            if (prod != {{32{prod[31]}}, prod[31:0]}) f.ovf = 1'b1;
         end
         OP_DIV, OP_MOD: begin
            if (b == 0) begin
               f.zdiv = 1'b1;
            end else begin
               wr = 1'b1;
               if (t.op == OP_DIV) begin
                  q = qa / qb;
                  if (a[31] != b[31]) res = -q;
                  else begin
                     res = q;
                     if (q == MOST_NEG) f.ovf = 1'b1;
                  end
               end else begin
                  q = qa % qb;
                  res = a[31] ? -q : q;
               end
            end
         end
         OP_AND: begin res = a & b; wr = 1'b1; end
         OP_OR:  begin res = a | b; wr = 1'b1; end
         OP_XOR: begin res = a ^ b; wr = 1'b1; end
         OP_NOT: begin res = ~a; wr = 1'b1; end
         OP_SHL: begin res = (b >= 32) ? '0 : a << b[4:0]; wr = 1'b1; end
         OP_SHR: begin res = (s >= 32) ? '0 : r >> s[4:0]; wr = 1'b1; end
         OP_SHRA: begin
            res = (s >= 32) ? {32{r[31]}} : $unsigned($signed(r) >>> s[4:0]);
            wr = 1'b1;
         end
         OP_COMP: begin
            f.gt = $signed(a) > $signed(b);
            f.lt = $signed(a) < $signed(b);
            f.eq = a == b;
         end
         OP_JUMP:  jmp = 1'b1;
         OP_JNEG:  jmp = r[31];
         OP_JZER:  jmp = r == 0;
         OP_JPOS:  jmp = !r[31] && r != 0;
         OP_JNNEG: jmp = !r[31];
         OP_JNZER: jmp = r != 0;
         OP_JNPOS: jmp = r[31] || r == 0;
         OP_JLES:  jmp = f.lt;
         OP_JEQU:  jmp = f.eq;
         OP_JGRE:  jmp = f.gt;
         OP_JNLES: jmp = !f.lt;
         OP_JNEQU: jmp = !f.eq;
         OP_JNGRE: jmp = !f.gt;
         default: ;
      endcase
      model_flags = f;
      o.result = wr ? res : '0;
      o.write_result = wr;
      o.branch_taken = jmp;
      o.branch_target = jmp ? s : '0;
      o.greater_flag = f.gt;
      o.less_flag = f.lt;
      o.equal_flag = f.eq;
      o.overflow_flag = f.ovf;
      o.divide_by_zero_flag = f.zdiv;
      return o;
   endfunction

   // watch both channels and compare against the oldest expectation
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         model_flags = '0;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_rsp_q.push_back(execute_op(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected transaction", got.result, '0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.result !== want.result)
                  report_mismatch("result", got.result, want.result);
               if (got.write_result !== want.write_result)
                  report_mismatch("write_result", 32'(got.write_result),
                                  32'(want.write_result));
               if (got.branch_taken !== want.branch_taken)
                  report_mismatch("branch_taken", 32'(got.branch_taken),
                                  32'(want.branch_taken));
               if (got.branch_target !== want.branch_target)
                  report_mismatch("branch_target", got.branch_target, want.branch_target);
               if (got.greater_flag !== want.greater_flag)
                  report_mismatch("greater_flag", 32'(got.greater_flag),
                                  32'(want.greater_flag));
               if (got.less_flag !== want.less_flag)
                  report_mismatch("less_flag", 32'(got.less_flag), 32'(want.less_flag));
               if (got.equal_flag !== want.equal_flag)
                  report_mismatch("equal_flag", 32'(got.equal_flag), 32'(want.equal_flag));
               if (got.overflow_flag !== want.overflow_flag)
                  report_mismatch("overflow_flag", 32'(got.overflow_flag),
                                  32'(want.overflow_flag));
               if (got.divide_by_zero_flag !== want.divide_by_zero_flag)
                  report_mismatch("divide_by_zero_flag", 32'(got.divide_by_zero_flag),
                                  32'(want.divide_by_zero_flag));
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

### tb/integer_execute_unit_with_flags_test.sv
// stimulus and verdict for the integer execute unit with status flags
`timescale 1ns / 1ps
module integer_execute_unit_with_flags_test;
   import ieu_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_UNUSED_LAST = 5'd31;
   localparam logic [31:0] MOST_NEG = 32'h8000_0000;
   localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam int RANDOM_ITEMS = 1285;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   tx_idle_pct = 0, rx_idle_pct = 0;
   int   idle_cycles = 0;
   int   sent_count = 0;

   ieu_if #(.payload_type(req_type)) req_ch ();
   ieu_if #(.payload_type(rsp_type)) rsp_ch ();

   integer_execute_unit_with_flags dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   integer_execute_unit_with_flags_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_type mk(input logic [OP_WIDTH-1:0] op, input logic [31:0] a,
                                  input logic [31:0] b, input logic [31:0] r,
                                  input logic [31:0] s);
      req_type t;
      t.op = op;
      t.alu_a = a;
      t.alu_b = b;
      t.reg_value = r;
      t.second_operand = s;
      return t;
   endfunction

   // operand biased toward boundary values
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return '0;
         1: return ALL_ONES;
         2: return $urandom_range(1) ? MOST_NEG : MOST_POS;
         3: return $urandom_range(15) - 8;
         4: return $urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   // shift amount: mostly in range, sometimes at or past the width
   function automatic logic [31:0] pick_shift();
      case ($urandom_range(5))
         0: return $urandom_range(40, 32);
         1: return $urandom;
         default: return $urandom_range(31);
      endcase
   endfunction

   // drive one transaction and hold it until accepted
   task automatic send(input req_type t);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic send_random();
      logic [OP_WIDTH-1:0] op;
      logic [31:0] a, b, r, s;
      op = OP_WIDTH'($urandom_range(31));
      a = pick_operand();
      b = pick_operand();
      r = pick_operand();
      s = $urandom;
      if (op == OP_SHL) b = pick_shift();
      if (op == OP_SHR || op == OP_SHRA) s = pick_shift();
      if (op == OP_LOAD) s = pick_operand();
      if ((op == OP_DIV || op == OP_MOD) && $urandom_range(3) == 0) b = '0;
      send(mk(op, a, b, r, s));
      // a compare is sometimes followed by a flag-tested jump
      if (op == OP_COMP && $urandom_range(1))
         send(mk(OP_WIDTH'($urandom_range(OP_JNGRE, OP_JLES)), a, b, r, $urandom));
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corner cases
      tx_idle_pct = 27;
      rx_idle_pct = 70;
      send(mk(OP_NOP, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      send(mk(OP_UNUSED_LAST, 1, 2, 3, 4));
      send(mk(OP_LOAD, 0, 0, 0, MOST_NEG));
      send(mk(OP_JLES, 0, 0, 0, 32'h10));
      send(mk(OP_JNEQU, 0, 0, 0, 32'h11));
      send(mk(OP_ADD, MOST_POS, 1, 0, 0));
      send(mk(OP_SUB, MOST_NEG, 1, 0, 0));
      send(mk(OP_MUL, 0, MOST_NEG, 0, 0));
      send(mk(OP_MUL, 32'h0001_0000, 32'h0000_8000, 0, 0));
      send(mk(OP_MUL, 32'hFFFF_0000, 32'h0000_8000, 0, 0));
      send(mk(OP_DIV, 7, 0, 0, 0));
      send(mk(OP_MOD, MOST_NEG, ALL_ONES, 0, 0));
      send(mk(OP_DIV, MOST_NEG, ALL_ONES, 0, 0));
      send(mk(OP_MOD, -7, 2, 0, 0));
      send(mk(OP_DIV, -7, 2, 0, 0));
      send(mk(OP_AND, 32'hF0F0_F0F0, ALL_ONES, 0, 0));
      send(mk(OP_OR, 32'h0F0F_0F0F, MOST_NEG, 0, 0));
      send(mk(OP_XOR, ALL_ONES, 32'h1234_5678, 0, 0));
      send(mk(OP_NOT, 0, 0, 0, 0));
      send(mk(OP_SHL, 1, 32, 0, 0));
      send(mk(OP_SHL, ALL_ONES, 31, 0, 0));
      send(mk(OP_SHR, 0, 0, ALL_ONES, ALL_ONES));
      send(mk(OP_SHRA, 0, 0, MOST_NEG, 40));
      send(mk(OP_SHRA, 0, 0, MOST_NEG, 0));
      send(mk(OP_COMP, MOST_NEG, MOST_POS, 0, 0));
      send(mk(OP_JLES, 0, 0, 0, ALL_ONES));
      send(mk(OP_COMP, 5, 5, 0, 0));
      send(mk(OP_JEQU, 0, 0, 0, 32'h20));
      send(mk(OP_COMP, MOST_POS, MOST_NEG, 0, 0));
      send(mk(OP_JGRE, 0, 0, 0, 32'h30));
      send(mk(OP_JNGRE, 0, 0, 0, 32'h31));
      for (int j = OP_JUMP; j <= OP_JNPOS; j++) begin
         send(mk(OP_WIDTH'(j), 0, 0, MOST_NEG, 32'h40 + j));
         send(mk(OP_WIDTH'(j), 0, 0, 0, MOST_POS));
      end

      // random part in three idling phases
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            tx_idle_pct = 70;
            rx_idle_pct = 27;
         end else if (i == 2 * RANDOM_ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         send_random();
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("sent %0d instructions over all opcodes, corner operands and shifts,", sent_count);
      $display("under sender and receiver stalls in three idling phases");
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/ieu_pkg.sv
rtl/ieu_if.sv
rtl/ieu_ctrl.sv
rtl/ieu_dp.sv
rtl/integer_execute_unit_with_flags.sv
tb/integer_execute_unit_with_flags_checker.sv
tb/integer_execute_unit_with_flags_test.sv
